@@ rtl/mtsd_pkg.sv @@
// Shared constants, codes and types of the multitouch slot event decoder.
`default_nettype none
package mtsd_pkg;

  localparam int TOUCH_SLOTS   = 10;
  localparam int SLOT_W        = $clog2(TOUCH_SLOTS);
  localparam int SCREEN_WIDTH  = 800;
  localparam int SCREEN_HEIGHT = 480;
  localparam int SCR_W_BITS    = 12;

  localparam logic [16:0] Q_ONE = 17'h10000;

  localparam logic [4:0] EV_SYN = 5'd0;
  localparam logic [4:0] EV_KEY = 5'd1;
  localparam logic [4:0] EV_ABS = 5'd3;

  localparam logic [9:0] CODE_SYN_REPORT = 10'h000;
  localparam logic [9:0] CODE_BTN_TOUCH  = 10'h14a;
  localparam logic [9:0] CODE_ABS_X      = 10'h000;
  localparam logic [9:0] CODE_ABS_Y      = 10'h001;
  localparam logic [9:0] CODE_MT_SLOT    = 10'h02f;
  localparam logic [9:0] CODE_MT_X       = 10'h035;
  localparam logic [9:0] CODE_MT_Y       = 10'h036;
  localparam logic [9:0] CODE_MT_TRK_ID  = 10'h039;
  localparam logic [9:0] CODE_MT_PRESS   = 10'h03a;

  localparam logic [2:0] REG_X_MIN     = 3'd0;
  localparam logic [2:0] REG_X_MAX     = 3'd1;
  localparam logic [2:0] REG_Y_MIN     = 3'd2;
  localparam logic [2:0] REG_Y_MAX     = 3'd3;
  localparam logic [2:0] REG_P_MIN     = 3'd4;
  localparam logic [2:0] REG_P_MAX     = 3'd5;
  localparam logic [2:0] REG_P_ENABLE  = 3'd6;
  localparam logic [2:0] REG_MOUSE_EMU = 3'd7;

  typedef enum logic [2:0] {
    KIND_DOWN     = 3'd0,
    KIND_UP       = 3'd1,
    KIND_MOTION   = 3'd2,
    KIND_M_PRESS  = 3'd3,
    KIND_M_RELEASE = 3'd4,
    KIND_M_MOTION = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_SCAN,
    S_NORM_GO,
    S_NORM_WAIT,
    S_EMIT,
    S_MOUSE
  } state_t;

  typedef enum logic [1:0] {
    NSEL_X,
    NSEL_Y,
    NSEL_P
  } nsel_t;

endpackage
`default_nettype wire

@@ rtl/mtsd_norm.sv @@
// Iterative Q16 normalizer: one quotient bit per cycle through a shared subtractor.
`default_nettype none
module mtsd_norm (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] v,
  input  wire logic signed [15:0] lo,
  input  wire logic signed [15:0] hi,
  output logic                    done,
  output logic [16:0]             q
);
  import mtsd_pkg::*;

  logic signed [33:0] d_raw, d_abs;
  logic signed [16:0] s_raw;
  logic [16:0]        s_abs;
  logic               busy_r;
  logic               done_r;
  logic [16:0]        rem_r;
  logic [16:0]        span_r;
  logic [15:0]        quo_r;
  logic [4:0]         cnt_r;
  logic [16:0]        q_r;
  logic [17:0]        trial;
  logic               fits;

  always_comb begin
    d_raw = 34'(v) - 34'(lo);
    s_raw = 17'(hi) - 17'(lo);
    if (s_raw < 0) begin
      d_abs = -d_raw;
      s_abs = 17'(-s_raw);
    end else begin
      d_abs = d_raw;
      s_abs = s_raw;
    end
    trial = {rem_r, 1'b0};
    fits  = trial >= {1'b0, span_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (s_abs == '0 || d_abs <= 0) begin
          q_r    <= '0;
          done_r <= 1'b1;
        end else if (d_abs >= 34'(s_abs)) begin
          q_r    <= Q_ONE;
          done_r <= 1'b1;
        end else begin
          rem_r  <= d_abs[16:0];
          span_r <= s_abs;
          quo_r  <= '0;
          cnt_r  <= 5'd16;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= fits ? 17'(trial - {1'b0, span_r}) : trial[16:0];
        quo_r <= {quo_r[14:0], fits};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          q_r    <= {1'b0, quo_r[14:0], fits};
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule
`default_nettype wire

@@ rtl/multitouch_slot_event_decoder.sv @@
// Top level: slot table, event sequencer and result register of the touch decoder.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | event_type, event_code, event_value
//  out_    | output    | out_valid/out_stall| kind, finger_id, norm_x/y, pressure, mouse_x/y, last
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One event at a time; in_stall is high until all its results are loaded into the output register.
// Each finger result takes two normalizations, X then Y, in the shared divider;
// a pressure event takes one, and state-only events take none.
// Reset (synchronous, rst_n low) clears all slots and loads default ranges.
// A stalled result holds in the output register and pauses the sequencer.
`default_nettype none
module multitouch_slot_event_decoder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [4:0]         in_event_type,
  input  wire logic [9:0]         in_event_code,
  input  wire logic signed [31:0] in_event_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_kind,
  output logic signed [31:0]      out_finger_id,
  output logic [16:0]             out_norm_x,
  output logic [16:0]             out_norm_y,
  output logic [16:0]             out_pressure_out,
  output logic [9:0]              out_mouse_x,
  output logic [8:0]              out_mouse_y,
  output logic                    out_last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import mtsd_pkg::*;

  state_t state_r, state_nxt;

  logic signed [15:0] x_min_r, x_max_r, y_min_r, y_max_r, p_min_r, p_max_r;
  logic               p_en_r, mouse_emu_r;

  logic signed [31:0] trk_id_r [TOUCH_SLOTS];
  logic               active_r [TOUCH_SLOTS];
  logic               down_r   [TOUCH_SLOTS];
  logic signed [31:0] sx_r     [TOUCH_SLOTS];
  logic signed [31:0] sy_r     [TOUCH_SLOTS];
  logic [16:0]        spr_r    [TOUCH_SLOTS];
  logic [SLOT_W-1:0]  sel_r;

  logic [4:0]         ev_type_r;
  logic [9:0]         ev_code_r;
  logic signed [31:0] ev_val_r;

  logic [SLOT_W-1:0]  cur_r;
  logic               scan_r;
  kind_t              kind_r;
  logic signed [31:0] fid_r;
  logic [16:0]        pr_r;
  logic [16:0]        nx_r, ny_r;
  nsel_t              nsel_r;

  logic               ov_r, olast_r;
  logic [2:0]         okind_r;
  logic signed [31:0] ofid_r;
  logic [16:0]        onx_r, ony_r, opr_r;
  logic [9:0]         omx_r;
  logic [8:0]         omy_r;

  logic [TOUCH_SLOTS-1:0] elig;
  logic               more_after;
  logic               out_free;
  logic               mouse_on;
  logic               last_finger;
  logic               cont_scan;
  logic               norm_start, norm_done;
  logic [16:0]        norm_q;
  logic signed [31:0] nv;
  logic signed [15:0] nlo, nhi;
  logic [16+SCR_W_BITS-1:0] mx_prod, my_prod;
  logic [SLOT_W-1:0]  s_clamp;

  always_comb begin
    more_after = 1'b0;
    for (int j = 0; j < TOUCH_SLOTS; j++) begin
      elig[j] = active_r[j] && !trk_id_r[j][31];
      if (elig[j] && SLOT_W'(j) > cur_r) more_after = 1'b1;
    end
  end

  assign out_free    = !ov_r || !out_stall;
  assign mouse_on    = mouse_emu_r && (sel_r == '0);
  assign last_finger = !scan_r || !more_after;
  assign cont_scan   = scan_r && (cur_r != SLOT_W'(TOUCH_SLOTS - 1));
  assign norm_start  = (state_r == S_NORM_GO);

  always_comb begin
    case (nsel_r)
      NSEL_X:  begin nv = sx_r[cur_r];  nlo = x_min_r; nhi = x_max_r; end
      NSEL_Y:  begin nv = sy_r[cur_r];  nlo = y_min_r; nhi = y_max_r; end
      NSEL_P:  begin nv = ev_val_r;     nlo = p_min_r; nhi = p_max_r; end
      default: begin nv = ev_val_r;     nlo = p_min_r; nhi = p_max_r; end
    endcase
  end

  mtsd_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .v     (nv),
    .lo    (nlo),
    .hi    (nhi),
    .done  (norm_done),
    .q     (norm_q)
  );

  assign mx_prod = (16+SCR_W_BITS)'(nx_r) * (16+SCR_W_BITS)'(SCREEN_WIDTH);
  assign my_prod = (16+SCR_W_BITS)'(ny_r) * (16+SCR_W_BITS)'(SCREEN_HEIGHT);

  always_comb begin
    if (ev_val_r < 0) s_clamp = '0;
    else if (ev_val_r >= TOUCH_SLOTS) s_clamp = SLOT_W'(TOUCH_SLOTS - 1);
    else s_clamp = ev_val_r[SLOT_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DEC;
      S_DEC: begin
        state_nxt = S_IDLE;
        if (ev_type_r == EV_ABS && ev_code_r == CODE_MT_TRK_ID && ev_val_r == -1 &&
            active_r[sel_r]) state_nxt = S_NORM_GO;
        if (ev_type_r == EV_ABS && ev_code_r == CODE_MT_PRESS && p_en_r)
          state_nxt = S_NORM_GO;
        if (ev_type_r == EV_KEY && ev_code_r == CODE_BTN_TOUCH && ev_val_r == 0 &&
            active_r[0]) state_nxt = S_NORM_GO;
        if (ev_type_r == EV_SYN && ev_code_r == CODE_SYN_REPORT) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (elig[cur_r]) state_nxt = S_NORM_GO;
        else if (cur_r == SLOT_W'(TOUCH_SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_NORM_GO: state_nxt = S_NORM_WAIT;
      S_NORM_WAIT: begin
        if (norm_done) begin
          case (nsel_r)
            NSEL_X:  state_nxt = S_NORM_GO;
            NSEL_Y:  state_nxt = S_EMIT;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (mouse_on) state_nxt = S_MOUSE;
          else state_nxt = cont_scan ? S_SCAN : S_IDLE;
        end
      end
      S_MOUSE: if (out_free) state_nxt = cont_scan ? S_SCAN : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= 16'sd0;  x_max_r <= 16'sd4095;
      y_min_r <= 16'sd0;  y_max_r <= 16'sd4095;
      p_min_r <= 16'sd0;  p_max_r <= 16'sd255;
      p_en_r  <= 1'b0;    mouse_emu_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X_MIN:     x_min_r <= cfg_data;
        REG_X_MAX:     x_max_r <= cfg_data;
        REG_Y_MIN:     y_min_r <= cfg_data;
        REG_Y_MAX:     y_max_r <= cfg_data;
        REG_P_MIN:     p_min_r <= cfg_data;
        REG_P_MAX:     p_max_r <= cfg_data;
        REG_P_ENABLE:  p_en_r  <= cfg_data[0];
        REG_MOUSE_EMU: mouse_emu_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // slot table and sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < TOUCH_SLOTS; j++) begin
        trk_id_r[j] <= '0;
        active_r[j] <= 1'b0;
        down_r[j]   <= 1'b0;
        sx_r[j]     <= '0;
        sy_r[j]     <= '0;
        spr_r[j]    <= '0;
      end
      sel_r  <= '0;
      cur_r  <= '0;
      scan_r <= 1'b0;
      nsel_r <= NSEL_X;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ev_type_r <= in_event_type;
            ev_code_r <= in_event_code;
            ev_val_r  <= in_event_value;
          end
        end
        S_DEC: begin
          cur_r  <= sel_r;
          scan_r <= 1'b0;
          nsel_r <= NSEL_X;
          kind_r <= KIND_UP;
          pr_r   <= '0;
          if (ev_type_r == EV_ABS) begin
            case (ev_code_r)
              CODE_MT_SLOT: sel_r <= s_clamp;
              CODE_MT_TRK_ID: begin
                if (ev_val_r == -1) begin
                  if (active_r[sel_r]) begin
                    fid_r <= trk_id_r[sel_r];
                    active_r[sel_r] <= 1'b0;
                    trk_id_r[sel_r] <= -32'sd1;
                    down_r[sel_r]   <= 1'b0;
                  end
                end else begin
                  trk_id_r[sel_r] <= ev_val_r;
                  active_r[sel_r] <= 1'b1;
                  spr_r[sel_r]    <= Q_ONE;
                  down_r[sel_r]   <= 1'b0;
                end
              end
              CODE_MT_X: sx_r[sel_r] <= ev_val_r;
              CODE_MT_Y: sy_r[sel_r] <= ev_val_r;
              CODE_MT_PRESS: nsel_r <= NSEL_P;
              CODE_ABS_X: begin
                sx_r[0] <= ev_val_r;
                if (!active_r[0]) begin
                  active_r[0] <= 1'b1;
                  trk_id_r[0] <= '0;
                  down_r[0]   <= 1'b0;
                end
              end
              CODE_ABS_Y: sy_r[0] <= ev_val_r;
              default: ;
            endcase
          end else if (ev_type_r == EV_KEY) begin
            if (ev_code_r == CODE_BTN_TOUCH && ev_val_r == 0 && active_r[0]) begin
              cur_r       <= '0;
              fid_r       <= '0;
              active_r[0] <= 1'b0;
              down_r[0]   <= 1'b0;
            end
          end else if (ev_type_r == EV_SYN && ev_code_r == CODE_SYN_REPORT) begin
            cur_r  <= '0;
            scan_r <= 1'b1;
          end
        end
        S_SCAN: begin
          nsel_r <= NSEL_X;
          if (elig[cur_r]) begin
            fid_r         <= trk_id_r[cur_r];
            kind_r        <= down_r[cur_r] ? KIND_MOTION : KIND_DOWN;
            pr_r          <= spr_r[cur_r];
            down_r[cur_r] <= 1'b1;
          end else if (cur_r != SLOT_W'(TOUCH_SLOTS - 1)) begin
            cur_r <= cur_r + SLOT_W'(1);
          end
        end
        S_NORM_WAIT: begin
          if (norm_done) begin
            case (nsel_r)
              NSEL_X: begin nx_r <= norm_q; nsel_r <= NSEL_Y; end
              NSEL_Y: ny_r <= norm_q;
              default: spr_r[cur_r] <= norm_q;
            endcase
          end
        end
        S_EMIT: begin
          if (out_free && !mouse_on && cont_scan) cur_r <= cur_r + SLOT_W'(1);
        end
        S_MOUSE: begin
          if (out_free && cont_scan) cur_r <= cur_r + SLOT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if ((state_r == S_EMIT || state_r == S_MOUSE) && out_free) begin
        ov_r    <= 1'b1;
        okind_r <= (state_r == S_MOUSE) ? 3'(kind_r) + 3'd3 : 3'(kind_r);
        ofid_r  <= fid_r;
        onx_r   <= nx_r;
        ony_r   <= ny_r;
        opr_r   <= pr_r;
        omx_r   <= mx_prod[16 +: 10];
        omy_r   <= my_prod[16 +: 9];
        olast_r <= last_finger && (state_r == S_MOUSE || !mouse_on);
      end
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = ov_r;
  assign out_kind         = okind_r;
  assign out_finger_id    = ofid_r;
  assign out_norm_x       = onx_r;
  assign out_norm_y       = ony_r;
  assign out_pressure_out = opr_r;
  assign out_mouse_x      = omx_r;
  assign out_mouse_y      = omy_r;
  assign out_last         = olast_r;

endmodule
`default_nettype wire

@@ tb/tb_event_checker.sv @@
// Result checker for the touch event decoder: predicts each item's results and compares them.
`timescale 1ns / 1ps
module tb_event_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [4:0]         in_event_type,
  input  wire logic [9:0]         in_event_code,
  input  wire logic signed [31:0] in_event_value,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [2:0]         out_kind,
  input  wire logic signed [31:0] out_finger_id,
  input  wire logic [16:0]        out_norm_x,
  input  wire logic [16:0]        out_norm_y,
  input  wire logic [16:0]        out_pressure_out,
  input  wire logic [9:0]         out_mouse_x,
  input  wire logic [8:0]         out_mouse_y,
  input  wire logic               out_last,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output int                      fail_count,
  output int                      pending
);
  import mtsd_pkg::*;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] id;
    logic [16:0]        nx;
    logic [16:0]        ny;
    logic [16:0]        pr;
    logic [9:0]         mx;
    logic [8:0]         my;
    logic               last;
  } touch_result_t;

  touch_result_t touch_q[$];

  logic signed [15:0] rng_x_lo, rng_x_hi, rng_y_lo, rng_y_hi, rng_p_lo, rng_p_hi;
  logic press_en, mouse_en;
  logic signed [31:0] trk_id[TOUCH_SLOTS];
  logic               is_open[TOUCH_SLOTS];
  logic               down_done[TOUCH_SLOTS];
  logic signed [31:0] pos_x[TOUCH_SLOTS];
  logic signed [31:0] pos_y[TOUCH_SLOTS];
  logic [16:0]        press[TOUCH_SLOTS];
  int                 cur_slot;

  assign pending = touch_q.size();

  function automatic logic [16:0] scale_q16(logic signed [31:0] v, logic signed [15:0] lo,
                                            logic signed [15:0] hi);
    longint d, s;
    d = longint'(v) - longint'(lo);
    s = longint'(hi) - longint'(lo);
    if (s == 0) return 17'd0;
    if (s < 0) begin
      s = -s;
      d = -d;
    end
    if (d <= 0) return 17'd0;
    if (d >= s) return Q_ONE;
    return 17'((d * 65536) / s);
  endfunction

  task automatic push_touch(logic [2:0] k, logic signed [31:0] id, int sl, logic [16:0] pr);
    touch_result_t r;
    logic [16:0] nx, ny;
    nx = scale_q16(pos_x[sl], rng_x_lo, rng_x_hi);
    ny = scale_q16(pos_y[sl], rng_y_lo, rng_y_hi);
    r.kind = k;
    r.id = id;
    r.nx = nx;
    r.ny = ny;
    r.pr = pr;
    r.mx = 10'((longint'(nx) * SCREEN_WIDTH) >> 16);
    r.my = 9'((longint'(ny) * SCREEN_HEIGHT) >> 16);
    r.last = 1'b0;
    touch_q.push_back(r);
    if (mouse_en && cur_slot == 0) begin
      r.kind = k + 3'd3;
      touch_q.push_back(r);
    end
  endtask

  task automatic decode_event(logic [4:0] ty, logic [9:0] cd, logic signed [31:0] v);
    int s, base;
    s = cur_slot;
    base = touch_q.size();
    if (ty == EV_ABS) begin
      case (cd)
        CODE_MT_SLOT: cur_slot = (v < 0) ? 0 : (v >= TOUCH_SLOTS) ? TOUCH_SLOTS - 1 : v;
        CODE_MT_TRK_ID: begin
          if (v == -1) begin
            if (is_open[s]) begin
              push_touch(KIND_UP, trk_id[s], s, 17'd0);
              is_open[s] = 1'b0;
              trk_id[s] = -1;
              down_done[s] = 1'b0;
            end
          end else begin
            trk_id[s] = v;
            is_open[s] = 1'b1;
            press[s] = Q_ONE;
            down_done[s] = 1'b0;
          end
        end
        CODE_MT_X: pos_x[s] = v;
        CODE_MT_Y: pos_y[s] = v;
        CODE_MT_PRESS: if (press_en) press[s] = scale_q16(v, rng_p_lo, rng_p_hi);
        CODE_ABS_X: begin
          pos_x[0] = v;
          if (!is_open[0]) begin
            is_open[0] = 1'b1;
            trk_id[0] = 0;
            down_done[0] = 1'b0;
          end
        end
        CODE_ABS_Y: pos_y[0] = v;
        default: ;
      endcase
    end else if (ty == EV_KEY) begin
      if (cd == CODE_BTN_TOUCH && v == 0 && is_open[0]) begin
        push_touch(KIND_UP, 0, 0, 17'd0);
        is_open[0] = 1'b0;
        down_done[0] = 1'b0;
      end
    end else if (ty == EV_SYN && cd == CODE_SYN_REPORT) begin
      for (int i = 0; i < TOUCH_SLOTS; i++) begin
        if (is_open[i] && trk_id[i] >= 0) begin
          push_touch(down_done[i] ? KIND_MOTION : KIND_DOWN, trk_id[i], i, press[i]);
          down_done[i] = 1'b1;
        end
      end
    end
    if (touch_q.size() > base) touch_q[touch_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    touch_result_t got, want;
    if (!rst_n) begin
      rng_x_lo <= 16'sd0; rng_x_hi <= 16'sd4095;
      rng_y_lo <= 16'sd0; rng_y_hi <= 16'sd4095;
      rng_p_lo <= 16'sd0; rng_p_hi <= 16'sd255;
      press_en <= 1'b0; mouse_en <= 1'b0;
      cur_slot = 0;
      for (int i = 0; i < TOUCH_SLOTS; i++) begin
        trk_id[i] = 32'sd0; is_open[i] = 1'b0; down_done[i] = 1'b0;
        pos_x[i] = 32'sd0; pos_y[i] = 32'sd0; press[i] = 17'd0;
      end
      touch_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_X_MIN: rng_x_lo <= cfg_data;
          REG_X_MAX: rng_x_hi <= cfg_data;
          REG_Y_MIN: rng_y_lo <= cfg_data;
          REG_Y_MAX: rng_y_hi <= cfg_data;
          REG_P_MIN: rng_p_lo <= cfg_data;
          REG_P_MAX: rng_p_hi <= cfg_data;
          REG_P_ENABLE: press_en <= cfg_data[0];
          REG_MOUSE_EMU: mouse_en <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{out_kind, out_finger_id, out_norm_x, out_norm_y, out_pressure_out,
                out_mouse_x, out_mouse_y, out_last};
        if (touch_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result: %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = touch_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) decode_event(in_event_type, in_event_code, in_event_value);
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the touch decoder testbench: clock, reset, event stimulus, register writes, verdict.
`timescale 1ns / 1ps
module tb_top;
  import mtsd_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, out_stall = 1'b0, cfg_valid = 1'b0;
  logic [4:0] in_event_type = '0;
  logic [9:0] in_event_code = '0;
  logic signed [31:0] in_event_value = '0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  wire in_stall, out_valid, cfg_ready, out_last;
  wire [2:0] out_kind;
  wire signed [31:0] out_finger_id;
  wire [16:0] out_norm_x, out_norm_y, out_pressure_out;
  wire [9:0] out_mouse_x;
  wire [8:0] out_mouse_y;
  int fail_count, pending;
  int send_idle_pct = 17, recv_idle_pct = 53;
  bit hold_off = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  multitouch_slot_event_decoder uut (.*);
  tb_event_checker chk (.*);

  // random receiver stalls, or a long hold-off when requested
  always @(posedge clk) out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

  // valid stays high into the next item when no idle cycle comes between them
  task automatic send_event(logic [4:0] ty, logic [9:0] cd, logic signed [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_event_type <= ty;
    in_event_code <= cd;
    in_event_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic stop_input;
    in_valid <= 1'b0;
  endtask

  task automatic settle;
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic cfg_done;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return -$urandom_range(100);
      default: return $urandom_range(4200);
    endcase
  endfunction

  task automatic send_noise();
    case ($urandom_range(5))
      0: send_event(5'($urandom), 10'($urandom), $urandom);
      1: send_event(EV_ABS, CODE_MT_SLOT, $urandom_range(1) ? $urandom : $urandom_range(12));
      2: send_event(EV_KEY, $urandom_range(1) ? CODE_BTN_TOUCH : 10'($urandom), $urandom_range(1));
      3: send_event(EV_SYN, 10'($urandom_range(2)), 0);
      4: send_event(EV_ABS, CODE_MT_TRK_ID, -1);
      default: send_event(EV_ABS, $urandom_range(1) ? CODE_ABS_X : CODE_ABS_Y, rand_coord());
    endcase
  endtask

  // one contact report: select, open or move, optional pressure, optional lift, then sync
  task automatic send_contact();
    int sl;
    sl = $urandom_range(9);
    send_event(EV_ABS, CODE_MT_SLOT, sl);
    if ($urandom_range(3) == 0) send_event(EV_ABS, CODE_MT_TRK_ID, $urandom_range(1000));
    send_event(EV_ABS, CODE_MT_X, rand_coord());
    send_event(EV_ABS, CODE_MT_Y, rand_coord());
    if ($urandom_range(1)) send_event(EV_ABS, CODE_MT_PRESS, $urandom_range(300) - 20);
    if ($urandom_range(4) == 0) send_event(EV_ABS, CODE_MT_TRK_ID, -1);
    send_event(EV_SYN, CODE_SYN_REPORT, 0);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7) send_contact();
      else send_noise();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: open every slot, extremes, single-touch path, odd ids
    write_reg(REG_P_ENABLE, 16'd1);
    write_reg(REG_MOUSE_EMU, 16'd1);
    cfg_done();
    send_event(EV_ABS, CODE_ABS_X, 32'sh7fffffff);
    send_event(EV_ABS, CODE_ABS_Y, 32'sh80000000);
    send_event(EV_SYN, CODE_SYN_REPORT, 0);
    send_event(EV_SYN, CODE_SYN_REPORT, 0);
    send_event(EV_KEY, CODE_BTN_TOUCH, 1);
    send_event(EV_KEY, CODE_BTN_TOUCH, 0);
    send_event(EV_ABS, CODE_MT_SLOT, -5);
    send_event(EV_ABS, CODE_MT_TRK_ID, -1);
    send_event(EV_ABS, CODE_MT_TRK_ID, 32'sh7fffffff);
    send_event(EV_ABS, CODE_MT_PRESS, 32'sh80000000);
    for (int s = 1; s < TOUCH_SLOTS; s++) begin
      send_event(EV_ABS, CODE_MT_SLOT, (s == 9) ? 32'sh7fffffff : s);
      send_event(EV_ABS, CODE_MT_TRK_ID, (s == 3) ? -7 : s);
      send_event(EV_ABS, CODE_MT_X, s * 455);
    end
    send_event(EV_SYN, CODE_SYN_REPORT, 0);
    // long hold-off while the sender keeps offering items
    hold_off <= 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        send_event(EV_SYN, CODE_SYN_REPORT, 0);
        send_event(EV_ABS, CODE_MT_TRK_ID, -1);
        send_event(EV_SYN, 10'h3ff, 32'sh55555555);
        send_event(5'h1f, 10'h3ff, 32'shaaaaaaaa);
        stop_input();
      end
    join
    settle();

    write_reg(REG_X_MIN, 16'h8000);
    write_reg(REG_X_MAX, 16'h7fff);
    write_reg(REG_Y_MIN, 16'd100);
    write_reg(REG_Y_MAX, 16'd100);
    write_reg(REG_P_MIN, 16'd255);
    write_reg(REG_P_MAX, 16'd0);
    cfg_done();
    random_phase(11);
    stop_input();
    settle();

    send_idle_pct = 53;
    recv_idle_pct = 17;
    write_reg(REG_X_MIN, 16'd4095);
    write_reg(REG_X_MAX, 16'd0);
    write_reg(REG_Y_MIN, 16'd0);
    write_reg(REG_Y_MAX, 16'd4095);
    write_reg(REG_P_MIN, 16'h7fff);
    write_reg(REG_P_MAX, 16'h8000);
    write_reg(REG_MOUSE_EMU, 16'd0);
    cfg_done();
    random_phase(10);
    stop_input();
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_X_MIN, 16'd0);
    write_reg(REG_X_MAX, 16'd4095);
    write_reg(REG_P_MIN, 16'd0);
    write_reg(REG_P_MAX, 16'd255);
    write_reg(REG_P_ENABLE, 16'd0);
    write_reg(REG_MOUSE_EMU, 16'd1);
    cfg_done();
    random_phase(10);
    stop_input();
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
